// ===== rtl/tcb_pkg.sv =====
// Shared types, constants and the per-channel blend function of the
// translucent column blender. No dependencies.
`timescale 1ns / 1ps

package tcb_pkg;

  // Sizes and fixed-point format.
  localparam int DEF_MAX_TEX_HEIGHT = 1024;
  localparam int PALETTE_DEPTH      = 256;
  localparam int MAP_DEPTH          = 256;
  localparam int FRAC_BITS          = 16;
  localparam int MOD_DW             = 16;
  localparam int QUEUE_DEPTH        = 2;
  localparam int CFG_IDX_W          = 2;
  localparam int CFG_DATA_W         = 26;

  // Blend constants.
  localparam logic [7:0] FIRE_TINT_MASK = 8'h70;
  localparam logic [7:0] FX1_LIMIT      = 8'd2;

  // Reset values of the configuration registers.
  localparam logic [25:0] RST_FRAC_STEP  = 26'd65536;
  localparam logic [10:0] RST_TEX_HEIGHT = 11'd128;

  // Input actions.
  typedef enum logic [2:0] {
    ACT_LOAD_PAL   = 3'd0,
    ACT_LOAD_LIGHT = 3'd1,
    ACT_LOAD_TEX   = 3'd2,
    ACT_LOAD_WHITE = 3'd3,
    ACT_START      = 3'd4,
    ACT_PIXEL      = 3'd5
  } tcb_action_e;

  // Blend modes; the two unused codes behave as half.
  typedef enum logic [2:0] {
    MODE_MORE          = 3'd0,
    MODE_HI            = 3'd1,
    MODE_HALF          = 3'd2,
    MODE_FIRE          = 3'd3,
    MODE_FX1           = 3'd4,
    MODE_SEVENTY_FIVE  = 3'd5
  } tcb_mode_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLEND_MODE = 2'd0,
    CFG_FRAC_STEP  = 2'd1,
    CFG_TEX_HEIGHT = 2'd2
  } tcb_cfg_idx_e;

  // Commands handed from the front to the back.
  typedef enum logic [2:0] {
    OP_WR_PAL,
    OP_WR_LIGHT,
    OP_WR_TEX,
    OP_WR_WHITE,
    OP_START,
    OP_PIXEL
  } tcb_op_e;

  typedef struct packed {
    logic [2:0]        action;
    logic [9:0]        table_index;
    logic [23:0]       table_word;
    logic signed [31:0] frac_start;
    logic [7:0]        dest_red;
    logic [7:0]        dest_green;
    logic [7:0]        dest_blue;
  } tcb_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } tcb_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } tcb_rgb_t;

  typedef struct packed {
    tcb_op_e     op;
    logic [9:0]  index;
    logic [23:0] word;
    logic        start_neg;
    logic [15:0] start_mag;
    logic [15:0] start_frac;
    tcb_rgb_t    dest;
  } tcb_cmd_t;

  typedef struct packed {
    logic [2:0]  blend_mode;
    logic [25:0] frac_step;
  } tcb_cfg_t;

  // Blend of one 8-bit channel: d is the destination, s the source colour.
  function automatic logic [7:0] tcb_mix(input logic [2:0] mode, input logic [7:0] d,
                                         input logic [7:0] s, input logic opaque);
    logic [10:0] dw;
    logic [10:0] sw;
    logic [10:0] acc;
    logic [7:0]  res;
    dw  = {3'b000, d};
    sw  = {3'b000, s};
    acc = dw + sw;
    res = acc[8:1];
    unique case (mode)
      MODE_MORE: begin
        acc = (dw << 1) + dw + sw;
        res = acc[9:2];
      end
      MODE_HI: begin
        acc = (dw << 3) - dw + sw;
        res = acc[10:3];
      end
      MODE_FIRE: begin
        acc = {3'b000, d | ({1'b0, s[7:1]} & FIRE_TINT_MASK)} + sw;
        res = acc[8:1];
      end
      MODE_FX1: begin
        res = opaque ? s : acc[8:1];
      end
      MODE_SEVENTY_FIVE: begin
        acc = (sw << 1) + sw + dw;
        res = acc[9:2];
      end
      default: begin
        res = acc[8:1];
      end
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/tcb_fifo.sv =====
// Small synchronous queue used between front and back and on the result side.
// Depends on tcb_pkg for its default depth.
`timescale 1ns / 1ps

module tcb_fifo import tcb_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [Width-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] rdata,
  output logic             empty
);

  localparam int PW   = $clog2(Depth);
  localparam int CNTW = $clog2(Depth + 1);

  logic [Width-1:0] mem_r [Depth];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CNTW-1:0]  count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNTW'(Depth));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Storage; written only on a transfer in.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/tcb_modulo.sv =====
// Bit-serial restoring remainder unit: dividend mod divisor, one bit a cycle.
// Depends on tcb_pkg for the dividend width.
`timescale 1ns / 1ps

module tcb_modulo import tcb_pkg::*; #(
  parameter int MAX_TEX_HEIGHT = DEF_MAX_TEX_HEIGHT
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [MOD_DW-1:0]                      dividend,
  input  logic [$clog2(MAX_TEX_HEIGHT + 1)-1:0]  divisor,
  output logic                                   done,
  output logic [$clog2(MAX_TEX_HEIGHT + 1)-1:0]  rem
);

  localparam int HW   = $clog2(MAX_TEX_HEIGHT + 1);
  localparam int CNTW = $clog2(MOD_DW + 1);

  logic [MOD_DW-1:0] dvd_r;
  logic [HW-1:0]     div_r;
  logic [HW-1:0]     rem_r;
  logic [HW-1:0]     rem_nxt;
  logic [CNTW-1:0]   cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [HW:0]       trial;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    trial   = {rem_r, dvd_r[MOD_DW-1]};
    rem_nxt = trial[HW-1:0];
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = HW'(trial - {1'b0, div_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r  <= dividend;
        div_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= CNTW'(MOD_DW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        dvd_r <= dvd_r << 1;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/tcb_front.sv =====
// Front of the blender: classifies accepted items into back-end commands,
// drops ignored items and splits the start coordinate. Depends on tcb_pkg.
`timescale 1ns / 1ps

module tcb_front import tcb_pkg::*; #(
  parameter int MAX_TEX_HEIGHT = DEF_MAX_TEX_HEIGHT
) (
  input  logic     item_valid,
  input  tcb_in_t  item,
  output logic     cmd_push,
  output tcb_cmd_t cmd
);

  logic [31:0] idx32;
  logic [15:0] whole;
  logic        useful;

  always_comb begin
    idx32 = 32'(item.table_index);
    // Integer part of the 16.16 start; a negative value is carried as its
    // one's complement so the back end only divides non-negative numbers.
    whole = item.frac_start[31:FRAC_BITS];

    cmd.op         = OP_PIXEL;
    cmd.index      = item.table_index;
    cmd.word       = item.table_word;
    cmd.start_neg  = whole[15];
    cmd.start_mag  = whole[15] ? ~whole : whole;
    cmd.start_frac = item.frac_start[FRAC_BITS-1:0];
    cmd.dest.red   = item.dest_red;
    cmd.dest.green = item.dest_green;
    cmd.dest.blue  = item.dest_blue;
    useful         = 1'b0;

    unique case (item.action)
      ACT_LOAD_PAL: begin
        cmd.op = OP_WR_PAL;
        useful = idx32 < 32'(PALETTE_DEPTH);
      end
      ACT_LOAD_LIGHT: begin
        cmd.op = OP_WR_LIGHT;
        useful = idx32 < 32'(MAP_DEPTH);
      end
      ACT_LOAD_TEX: begin
        cmd.op = OP_WR_TEX;
        useful = idx32 < 32'(MAX_TEX_HEIGHT);
      end
      ACT_LOAD_WHITE: begin
        cmd.op = OP_WR_WHITE;
        useful = idx32 < 32'(MAP_DEPTH);
      end
      ACT_START: begin
        cmd.op = OP_START;
        useful = 1'b1;
      end
      ACT_PIXEL: begin
        cmd.op = OP_PIXEL;
        useful = 1'b1;
      end
      default: begin
        useful = 1'b0;
      end
    endcase

    cmd_push = item_valid && useful;
  end

endmodule

// ===== rtl/tcb_back.sv =====
// Back of the blender: table memories, texture coordinate, pixel sequencer
// and the coordinate wrap. Depends on tcb_pkg and tcb_modulo.
`timescale 1ns / 1ps

module tcb_back import tcb_pkg::*; #(
  parameter int MAX_TEX_HEIGHT = DEF_MAX_TEX_HEIGHT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tcb_cfg_t                              cfg,
  input  logic [$clog2(MAX_TEX_HEIGHT + 1)-1:0] height,
  input  logic                                  cmd_valid,
  input  tcb_cmd_t                              cmd,
  output logic                                  cmd_pop,
  input  logic                                  res_full,
  output logic                                  res_push,
  output tcb_out_t                              res_data
);

  localparam int CIW = $clog2(MAX_TEX_HEIGHT);
  localparam int HW  = $clog2(MAX_TEX_HEIGHT + 1);
  localparam int CW  = CIW + FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEX,
    ST_LOOK,
    ST_EMIT,
    ST_MOD
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     coord_r;
  logic [MOD_DW-1:0] isum_r;
  logic [15:0]       frac_keep_r;
  logic              for_start_r;
  logic              neg_r;
  tcb_rgb_t          dest_r;
  logic              mod_go_r;
  logic [MOD_DW-1:0] mod_dvd_r;

  logic [23:0] pal_mem   [PALETTE_DEPTH];
  logic [7:0]  light_mem [MAP_DEPTH];
  logic [7:0]  white_mem [MAP_DEPTH];
  logic [7:0]  tex_mem   [MAX_TEX_HEIGHT];
  logic [23:0] pal_q;
  logic [7:0]  light_q;
  logic [7:0]  white_q;
  logic [7:0]  tex_q;

  logic              take;
  logic [31:0]       idx32;
  logic [CIW-1:0]    coord_int;
  logic [CIW-1:0]    tex_raddr;
  logic [7:0]        pal_raddr;
  logic              mode34;
  logic [16:0]       frac_sum;
  logic [MOD_DW-1:0] int_sum;
  logic [MOD_DW-1:0] height16;
  logic [MOD_DW-1:0] height2;
  logic [MOD_DW-1:0] wrap_int;
  logic [HW-1:0]     start_int;
  logic [HW-1:0]     new_int;
  logic              mod_done;
  logic [HW-1:0]     mod_rem;
  logic              opaque;

  // Command handshake and table write enables.
  assign take    = (state_r == ST_IDLE) && cmd_valid;
  assign cmd_pop = take;
  assign idx32   = 32'(cmd.index);

  // Coordinate arithmetic for the step after a pixel.
  assign coord_int = coord_r[CW-1:FRAC_BITS];
  assign tex_raddr = (32'(coord_int) >= 32'(MAX_TEX_HEIGHT)) ? '0 : coord_int;
  assign frac_sum  = {1'b0, coord_r[FRAC_BITS-1:0]} + {1'b0, cfg.frac_step[FRAC_BITS-1:0]};
  assign int_sum   = MOD_DW'(coord_int) + MOD_DW'(cfg.frac_step[25:FRAC_BITS])
                   + MOD_DW'(frac_sum[FRAC_BITS]);
  assign height16  = MOD_DW'(height);
  assign height2   = height16 << 1;
  assign wrap_int  = (isum_r < height16) ? isum_r : isum_r - height16;

  // Remainder back to a coordinate; a negative start lands at h-1-r.
  assign start_int = neg_r ? (height - HW'(1) - mod_rem) : mod_rem;
  assign new_int   = for_start_r ? start_int : mod_rem;

  // Fire and fx1 index the palette with the texel directly.
  assign mode34    = (cfg.blend_mode == MODE_FIRE) || (cfg.blend_mode == MODE_FX1);
  assign pal_raddr = mode34 ? tex_q : light_q;

  // Memories: one write port from the command, one registered read each.
  always_ff @(posedge clk) begin
    if (take && (cmd.op == OP_WR_PAL)) begin
      pal_mem[cmd.index[7:0]] <= cmd.word;
    end
    pal_q <= pal_mem[pal_raddr];
  end

  always_ff @(posedge clk) begin
    if (take && (cmd.op == OP_WR_LIGHT)) begin
      light_mem[cmd.index[7:0]] <= cmd.word[7:0];
    end
    light_q <= light_mem[tex_q];
  end

  always_ff @(posedge clk) begin
    if (take && (cmd.op == OP_WR_WHITE)) begin
      white_mem[cmd.index[7:0]] <= cmd.word[7:0];
    end
    white_q <= white_mem[tex_q];
  end

  always_ff @(posedge clk) begin
    if (take && (cmd.op == OP_WR_TEX)) begin
      tex_mem[idx32[CIW-1:0]] <= cmd.word[7:0];
    end
    tex_q <= tex_mem[tex_raddr];
  end

  // fx1 stays opaque while the texel and its white blend are within the limit.
  always_comb begin
    if (tex_q >= white_q) begin
      opaque = (tex_q - white_q) <= FX1_LIMIT;
    end else begin
      opaque = (white_q - tex_q) <= FX1_LIMIT;
    end
  end

  // Result colour.
  assign res_push           = (state_r == ST_EMIT) && !res_full;
  assign res_data.out_red   = tcb_mix(cfg.blend_mode, dest_r.red,   pal_q[23:16], opaque);
  assign res_data.out_green = tcb_mix(cfg.blend_mode, dest_r.green, pal_q[15:8],  opaque);
  assign res_data.out_blue  = tcb_mix(cfg.blend_mode, dest_r.blue,  pal_q[7:0],   opaque);

  // Shared remainder unit for column starts and long coordinate wraps.
  tcb_modulo #(
    .MAX_TEX_HEIGHT(MAX_TEX_HEIGHT)
  ) u_modulo (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_go_r),
    .dividend(mod_dvd_r),
    .divisor (height),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  // Sequencer: tables are read in a chain texel, light, palette.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      coord_r  <= '0;
      mod_go_r <= 1'b0;
    end else begin
      mod_go_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              OP_START: begin
                mod_go_r    <= 1'b1;
                mod_dvd_r   <= cmd.start_mag;
                neg_r       <= cmd.start_neg;
                for_start_r <= 1'b1;
                frac_keep_r <= cmd.start_frac;
                state_r     <= ST_MOD;
              end
              OP_PIXEL: begin
                dest_r      <= cmd.dest;
                isum_r      <= int_sum;
                frac_keep_r <= frac_sum[FRAC_BITS-1:0];
                state_r     <= ST_TEX;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_TEX: begin
          state_r <= ST_LOOK;
        end
        ST_LOOK: begin
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!res_full) begin
            if (isum_r < height2) begin
              coord_r <= {wrap_int[CIW-1:0], frac_keep_r};
              state_r <= ST_IDLE;
            end else begin
              mod_go_r    <= 1'b1;
              mod_dvd_r   <= isum_r;
              for_start_r <= 1'b0;
              state_r     <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            coord_r <= {new_int[CIW-1:0], frac_keep_r};
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/translucent_column_blender.sv =====
// Top level of the translucent column blender: configuration registers,
// input queue, front, back and result queue. Depends on tcb_pkg and all tcb_ modules.
`timescale 1ns / 1ps

// Usage:
//   Items enter on in_data with in_push while in_full is low. Load actions fill
//   the palette, light map, texel column and white-blend tables; a start item
//   sets the texture coordinate; a pixel item yields one blended colour.
//   Results leave on out_data while out_empty is low and transfer on out_pop.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
// Sequence:
//   A two-entry queue holds items for the back end, which takes a new item
//   only once it is idle again. A pixel goes through texel, light and palette
//   reads in a chain, then the blend, and waits while the result queue is full.
//   When coordinate plus step reaches twice the texture height, the wrap runs
//   through the bit-serial remainder unit. A start item also runs through the
//   same unit.
// Reset:
//   Coordinate zero, blend mode half, step 1.0, height 128; tables hold
//   nothing until loaded. A stalled result queue stops the back end after two
//   waiting results; the input queue then fills and raises in_full.

module translucent_column_blender import tcb_pkg::*; #(
  parameter int MAX_TEX_HEIGHT = DEF_MAX_TEX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  tcb_in_t               in_data,
  output logic                  out_empty,
  input  logic                  out_pop,
  output tcb_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int HW   = $clog2(MAX_TEX_HEIGHT + 1);
  localparam int CMDW = $bits(tcb_cmd_t);
  localparam int RESW = $bits(tcb_out_t);

  logic [2:0]  blend_mode_r;
  logic [25:0] frac_step_r;
  logic [10:0] tex_height_r;

  tcb_cfg_t      cfg;
  logic [31:0]   h_raw;
  logic [31:0]   h_sel;
  logic [HW-1:0] height;

  logic            front_push;
  tcb_cmd_t        front_cmd;
  logic            cmd_full;
  logic            cmd_empty;
  logic            cmd_pop;
  logic [CMDW-1:0] cmd_bits;
  tcb_cmd_t        cmd_q;

  logic            res_full;
  logic            res_push;
  tcb_out_t        res_data;
  logic [RESW-1:0] res_bits;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_mode_r <= MODE_HALF;
      frac_step_r  <= RST_FRAC_STEP;
      tex_height_r <= RST_TEX_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLEND_MODE: blend_mode_r <= cfg_wdata[2:0];
        CFG_FRAC_STEP:  frac_step_r  <= cfg_wdata[25:0];
        CFG_TEX_HEIGHT: tex_height_r <= cfg_wdata[10:0];
        default: begin
          blend_mode_r <= blend_mode_r;
        end
      endcase
    end
  end

  // A height of zero or beyond the column depth is taken as the full depth.
  assign h_raw = 32'(tex_height_r);
  assign h_sel = ((h_raw == '0) || (h_raw > 32'(MAX_TEX_HEIGHT))) ?
                 32'(MAX_TEX_HEIGHT) : h_raw;
  assign height = h_sel[HW-1:0];

  assign cfg.blend_mode = blend_mode_r;
  assign cfg.frac_step  = frac_step_r;

  // Input side: classify and queue commands.
  assign in_full = cmd_full;

  tcb_front #(
    .MAX_TEX_HEIGHT(MAX_TEX_HEIGHT)
  ) u_front (
    .item_valid(in_push && !cmd_full),
    .item      (in_data),
    .cmd_push  (front_push),
    .cmd       (front_cmd)
  );

  tcb_fifo #(
    .Width(CMDW),
    .Depth(QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (front_push),
    .wdata(front_cmd),
    .full (cmd_full),
    .pop  (cmd_pop),
    .rdata(cmd_bits),
    .empty(cmd_empty)
  );

  assign cmd_q = tcb_cmd_t'(cmd_bits);

  // Execution.
  tcb_back #(
    .MAX_TEX_HEIGHT(MAX_TEX_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .height   (height),
    .cmd_valid(!cmd_empty),
    .cmd      (cmd_q),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data)
  );

  // Result side: each transfer out removes the oldest result.
  tcb_fifo #(
    .Width(RESW),
    .Depth(QUEUE_DEPTH)
  ) u_res_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res_data),
    .full (res_full),
    .pop  (out_pop),
    .rdata(res_bits),
    .empty(out_empty)
  );

  assign out_data = tcb_out_t'(res_bits);

endmodule

// ===== tb/blend_checker.sv =====
// Checker for the translucent column blender: watches the input, result and register
// ports, keeps its own copy of the tables and coordinate, and compares every result.
// Depends on tcb_pkg for the transfer types, action and mode codes.
`timescale 1ns / 1ps

module blend_checker import tcb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_full,
  input  tcb_in_t               in_data,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  tcb_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    pending,
  output int                    results_checked
);

  localparam int REPORT_LIMIT = 10;

  // Shadow copies of the tables, the coordinate and the registers.
  logic [23:0] palette_shadow [PALETTE_DEPTH];
  logic [7:0]  light_shadow [MAP_DEPTH];
  logic [7:0]  texel_shadow [DEF_MAX_TEX_HEIGHT];
  logic [7:0]  white_shadow [MAP_DEPTH];
  logic [25:0] coord;
  logic [2:0]  mode;
  logic [25:0] step;
  logic [10:0] height;

  tcb_out_t color_queue [$];
  int errors;
  int checked;

  // Height in 16.16, with out-of-range heights taken as the full column.
  function automatic longint wrap_span();
    int h;
    h = height;
    if (h == 0 || h > DEF_MAX_TEX_HEIGHT) h = DEF_MAX_TEX_HEIGHT;
    return longint'(h) << FRAC_BITS;
  endfunction

  // One channel of the blend; spare mode codes behave as half.
  function automatic logic [7:0] blend_channel(input logic [2:0] m, input logic [7:0] d,
                                               input logic [7:0] s, input bit opaque);
    int unsigned dd;
    int unsigned ss;
    int unsigned mask;
    dd = d;
    ss = s;
    mask = FIRE_TINT_MASK;
    case (m)
      MODE_MORE:         return (3 * dd + ss) >> 2;
      MODE_HI:           return (7 * dd + ss) >> 3;
      MODE_FIRE:         return ((dd | ((ss >> 1) & mask)) + ss) >> 1;
      MODE_FX1:          return opaque ? ss : (dd + ss) >> 1;
      MODE_SEVENTY_FIVE: return (3 * ss + dd) >> 2;
      default:           return (dd + ss) >> 1;
    endcase
  endfunction

  // Apply one accepted item to the shadow state and queue its color, if any.
  task automatic predict_item(input tcb_in_t item);
    longint span;
    longint start_val;
    longint rem;
    logic [9:0]  row;
    logic [7:0]  texel;
    logic [7:0]  white;
    logic [23:0] color;
    int diff;
    bit opaque;
    tcb_out_t res;
    span = wrap_span();
    case (item.action)
      ACT_LOAD_PAL:
        if (item.table_index < PALETTE_DEPTH) palette_shadow[item.table_index] = item.table_word;
      ACT_LOAD_LIGHT:
        if (item.table_index < MAP_DEPTH) light_shadow[item.table_index] = item.table_word[7:0];
      ACT_LOAD_TEX:
        if (item.table_index < DEF_MAX_TEX_HEIGHT)
          texel_shadow[item.table_index] = item.table_word[7:0];
      ACT_LOAD_WHITE:
        if (item.table_index < MAP_DEPTH) white_shadow[item.table_index] = item.table_word[7:0];
      ACT_START: begin
        // True modulo, so negative starts land inside the column.
        start_val = $signed(item.frac_start);
        rem = start_val % span;
        if (rem < 0) rem = rem + span;
        coord = rem[25:0];
      end
      ACT_PIXEL: begin
        row = coord[25:16];
        texel = texel_shadow[row];
        if (mode == MODE_FIRE || mode == MODE_FX1) color = palette_shadow[texel];
        else color = palette_shadow[light_shadow[texel]];
        white = white_shadow[texel];
        diff = int'(texel) - int'(white);
        opaque = (diff <= int'(FX1_LIMIT)) && (diff >= -int'(FX1_LIMIT));
        res.out_red   = blend_channel(mode, item.dest_red, color[23:16], opaque);
        res.out_green = blend_channel(mode, item.dest_green, color[15:8], opaque);
        res.out_blue  = blend_channel(mode, item.dest_blue, color[7:0], opaque);
        color_queue.push_back(res);
        rem = (longint'(coord) + longint'(step)) % span;
        coord = rem[25:0];
      end
      default: ;
    endcase
  endtask

  // Compare one result transfer with the oldest expected color.
  task automatic compare_result(input tcb_out_t got);
    tcb_out_t want;
    if (color_queue.size() == 0) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("Result %h arrived with no pixel waiting, at %0t", got, $time);
    end else begin
      want = color_queue.pop_front();
      checked++;
      if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
          got.out_blue !== want.out_blue) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("Color mismatch at %0t: expected r %h g %h b %h, got r %h g %h b %h",
                   $time, want.out_red, want.out_green, want.out_blue,
                   got.out_red, got.out_green, got.out_blue);
      end
    end
  endtask

  // All channels are sampled at the rising edge, results before new items.
  always @(posedge clk) begin
    if (!rst_n) begin
      coord  = '0;
      mode   = MODE_HALF;
      step   = RST_FRAC_STEP;
      height = RST_TEX_HEIGHT;
      color_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLEND_MODE: mode = cfg_wdata[2:0];
          CFG_FRAC_STEP:  step = cfg_wdata;
          CFG_TEX_HEIGHT: height = cfg_wdata[10:0];
          default: ;
        endcase
      end
      if (out_pop && !out_empty) compare_result(out_data);
      if (in_push && !in_full) predict_item(in_data);
    end
    mismatch_count  <= errors;
    pending         <= color_queue.size();
    results_checked <= checked;
  end

endmodule

// ===== tb/translucent_column_blender_test.sv =====
// Top of the translucent column blender testbench: clock, reset, stimulus, result
// draining and the verdict. Depends on tcb_pkg, blend_checker and the block itself.
`timescale 1ns / 1ps

module translucent_column_blender_test;
  import tcb_pkg::*;

  localparam int SETTLE_CYCLES   = 40;
  localparam int SQUEEZE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SWEEP_PHASES    = 8;
  localparam int SWEEP_ITEMS     = 12;
  localparam int RANDOM_PHASES   = 8;
  localparam int RANDOM_ITEMS    = 45;
  localparam int SQUEEZE_PHASE   = 2;

  // Codes with no name in the package.
  localparam logic [2:0] ACT_SPARE_A  = 3'd6;
  localparam logic [2:0] ACT_SPARE_B  = 3'd7;
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  tcb_in_t               in_data = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  tcb_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BLEND_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int   mismatch_count;
  int   pending;
  int   results_checked;
  int   idle_cycles = 0;
  int   items_sent = 0;
  int   settings_count = 0;
  int   send_calm = 0;
  int   pop_calm = 0;
  bit   sender_steady = 1'b0;
  logic squeeze_req = 1'b0;

  translucent_column_blender i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  blend_checker i_blend_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_data         (in_data),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  always #1 clk = ~clk;

  // Idle length for either side: mostly short, a few long, with calm stretches.
  function automatic int pause_length(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(30, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Every field random, so the unused ones toggle as well.
  function automatic tcb_in_t random_fields();
    tcb_in_t it;
    it.action      = $urandom;
    it.table_index = $urandom;
    it.table_word  = $urandom;
    it.frac_start  = $urandom;
    it.dest_red    = $urandom;
    it.dest_green  = $urandom;
    it.dest_blue   = $urandom;
    return it;
  endfunction

  function automatic tcb_in_t load_item(input logic [2:0] act, input logic [9:0] idx,
                                        input logic [23:0] word);
    tcb_in_t it;
    it = random_fields();
    it.action      = act;
    it.table_index = idx;
    it.table_word  = word;
    return it;
  endfunction

  function automatic tcb_in_t start_item(input logic [31:0] value);
    tcb_in_t it;
    it = random_fields();
    it.action     = ACT_START;
    it.frac_start = value;
    return it;
  endfunction

  function automatic tcb_in_t pixel_item();
    tcb_in_t it;
    it = random_fields();
    it.action = ACT_PIXEL;
    return it;
  endfunction

  // White-map entries mostly near their own index, so fx1 goes both ways.
  function automatic logic [23:0] white_word(input logic [7:0] idx);
    int r;
    logic [7:0]  off;
    logic [7:0]  low;
    logic [15:0] high_bits;
    r = $urandom_range(0, 9);
    off = $urandom_range(0, 4);
    high_bits = $urandom;
    if (r < 5) low = idx + off - 8'd2;
    else if (r < 7) low = $urandom_range(0, 1) ? idx + 8'd3 : idx - 8'd3;
    else low = $urandom;
    return {high_bits, low};
  endfunction

  // Offer one item and hold it until the block takes the transfer.
  task automatic push_item(input tcb_in_t item);
    int gap;
    gap = sender_steady ? 0 : pause_length(send_calm);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= item;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
  endtask

  // Stop sending and wait until every expected color has come back.
  task automatic drain_block();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers; unused upper data bits carry junk.
  task automatic apply_settings(input logic [2:0] m, input logic [25:0] step,
                                input logic [10:0] height);
    logic [22:0] junk_mode;
    logic [14:0] junk_height;
    junk_mode   = $urandom;
    junk_height = $urandom;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BLEND_MODE;
    cfg_wdata <= {junk_mode, m};
    @(posedge clk);
    cfg_index <= CFG_FRAC_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_index <= CFG_TEX_HEIGHT;
    cfg_wdata <= {junk_height, height};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  // Mostly column runs of pixels and starts, with loads and noise mixed in.
  // Ignored items (spare actions, out-of-range loads) do not count toward n.
  task automatic run_mix(input int n);
    int counted;
    int r;
    bit counts;
    tcb_in_t it;
    counted = 0;
    while (counted < n) begin
      r = $urandom_range(0, 99);
      counts = 1'b1;
      it = random_fields();
      if (r < 55) begin
        it.action = ACT_PIXEL;
      end else if (r < 63) begin
        it.action = ACT_START;
        if ($urandom_range(0, 1)) it.frac_start = $urandom_range(0, 32'h1FFF_FFFF) - 32'h1000_0000;
      end else if (r < 71) begin
        it.action = ACT_LOAD_TEX;
      end else if (r < 90) begin
        case ($urandom_range(0, 2))
          0: it.action = ACT_LOAD_PAL;
          1: it.action = ACT_LOAD_LIGHT;
          default: it.action = ACT_LOAD_WHITE;
        endcase
        if ($urandom_range(0, 7) == 0) it.table_index = $urandom_range(256, 1023);
        else it.table_index = $urandom_range(0, 255);
        if (it.action == ACT_LOAD_WHITE) it.table_word = white_word(it.table_index[7:0]);
        counts = it.table_index < 256;
      end else if (r < 95) begin
        it.action = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
        counts = 1'b0;
      end else begin
        it.action = ACT_START;
        case ($urandom_range(0, 3))
          0: it.frac_start = 32'h8000_0000;
          1: it.frac_start = 32'h7FFF_FFFF;
          2: it.frac_start = 32'h0000_0000;
          default: it.frac_start = 32'hFFFF_FFFF;
        endcase
      end
      push_item(it);
      if (counts) counted++;
    end
  endtask

  // Result side: pop with random holds, and one long hold on request.
  initial begin : receiver
    int stall;
    bit squeezed;
    stall = 0;
    squeezed = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        stall = SQUEEZE_CYCLES;
      end
      if (stall > 0) begin
        out_pop <= 1'b0;
        stall--;
      end else begin
        out_pop <= 1'b1;
      end
      @(posedge clk);
      if (out_pop && !out_empty) stall = pause_length(pop_calm);
    end
  end

  // Watchdog: too many cycles without any transfer ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("No transfer for %0d cycles, %0d colors still expected", idle_cycles, pending);
      $display("translucent_column_blender_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [2:0]  m;
    logic [25:0] step;
    logic [10:0] height;
    int h;
    int r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every table entry once, so no pixel ever reads an unwritten one.
    for (int i = 0; i < MAP_DEPTH; i++) begin
      push_item(load_item(ACT_LOAD_PAL, i, $urandom));
      push_item(load_item(ACT_LOAD_LIGHT, i, $urandom));
      push_item(load_item(ACT_LOAD_WHITE, i, white_word(i)));
    end
    for (int i = 0; i < DEF_MAX_TEX_HEIGHT; i++) push_item(load_item(ACT_LOAD_TEX, i, $urandom));

    // Directed items at the reset settings: field extremes, ignored loads,
    // start coordinate extremes, the wrap at the column end, spare actions.
    push_item(load_item(ACT_LOAD_PAL, 10'd0, 24'hFF_FFFF));
    push_item(load_item(ACT_LOAD_PAL, 10'd255, 24'h00_0000));
    push_item(load_item(ACT_LOAD_PAL, 10'd1023, $urandom));
    push_item(load_item(ACT_LOAD_LIGHT, 10'd256, $urandom));
    push_item(load_item(ACT_LOAD_WHITE, 10'd1023, $urandom));
    push_item(load_item(ACT_LOAD_LIGHT, 10'd255, 24'hFF_FF00));
    push_item(load_item(ACT_LOAD_TEX, 10'd0, 24'h00_00FF));
    push_item(load_item(ACT_LOAD_TEX, 10'd1023, 24'hFF_FF00));
    push_item(start_item(32'h0000_0000));
    in_data <= pixel_item();
    push_item('{action: ACT_PIXEL, table_index: 10'd0, table_word: 24'd0,
                frac_start: 32'd0, dest_red: 8'h00, dest_green: 8'h00, dest_blue: 8'h00});
    push_item('{action: ACT_PIXEL, table_index: 10'h3FF, table_word: 24'hFF_FFFF,
                frac_start: 32'hFFFF_FFFF, dest_red: 8'hFF, dest_green: 8'hFF, dest_blue: 8'hFF});
    push_item(start_item(32'h7FFF_FFFF));
    push_item(pixel_item());
    push_item(start_item(32'h8000_0000));
    push_item(pixel_item());
    push_item(start_item(32'hFFFF_FFFF));
    push_item(pixel_item());
    push_item(load_item(ACT_SPARE_A, $urandom, $urandom));
    push_item(load_item(ACT_SPARE_B, $urandom, $urandom));
    push_item(start_item(32'h007F_FFFF));
    push_item(pixel_item());
    push_item(pixel_item());
    drain_block();

    // Sweep of settings: every mode code, step and height extremes.
    for (int k = 0; k < SWEEP_PHASES; k++) begin
      case (k)
        0: apply_settings(MODE_MORE, 26'd65536, 11'd128);
        1: apply_settings(MODE_HI, 26'd0, 11'd1);
        2: apply_settings(MODE_FIRE, 26'h3FF_FFFF, 11'd1024);
        3: apply_settings(MODE_FX1, 26'd1, 11'd2);
        4: apply_settings(MODE_SEVENTY_FIVE, 26'd98304, 11'd0);
        5: apply_settings(MODE_SPARE_A, 26'd196608, 11'd2047);
        6: apply_settings(MODE_SPARE_B, 26'd12345, 11'd1025);
        default: apply_settings(MODE_HALF, 26'h3FF_FFFF, 11'd1);
      endcase
      push_item(start_item($urandom));
      run_mix(SWEEP_ITEMS);
      drain_block();
    end

    // Random settings and random traffic; one phase fills the block while
    // the result side holds off.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      m = $urandom_range(0, 7);
      r = $urandom_range(0, 99);
      if (r < 10) height = $urandom_range(0, 1) ? 11'd0 : 11'($urandom_range(1025, 2047));
      else if (r < 20) height = $urandom_range(0, 1) ? 11'd1 : 11'd1024;
      else height = $urandom_range(1, 1024);
      h = (height == 0 || height > DEF_MAX_TEX_HEIGHT) ? DEF_MAX_TEX_HEIGHT : height;
      r = $urandom_range(0, 99);
      if (r < 30) step = $urandom_range(0, h * 65536 - 1);
      else if (r < 60) step = $urandom_range(0, 4 * 65536);
      else step = $urandom;
      apply_settings(m, step, height);
      if (p == SQUEEZE_PHASE) begin
        squeeze_req <= 1'b1;
        sender_steady = 1'b1;
      end
      run_mix(RANDOM_ITEMS);
      sender_steady = 1'b0;
      drain_block();
    end

    $display("Run covered %0d input transfers and %0d compared colors over %0d settings,",
             items_sent, results_checked, settings_count);
    $display("including all eight mode codes, heights 0 to 2047 and a full result stall.");
    if (mismatch_count == 0 && pending == 0) begin
      $display("translucent_column_blender_test OK");
    end else begin
      $display("translucent_column_blender_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== translucent_column_blender.f =====
rtl/tcb_pkg.sv
rtl/tcb_fifo.sv
rtl/tcb_modulo.sv
rtl/tcb_front.sv
rtl/tcb_back.sv
rtl/translucent_column_blender.sv
tb/blend_checker.sv
tb/translucent_column_blender_test.sv
